### rtl/address_resolution_table_macros.svh
// Assertion macros used by the port-level checker of the address resolution table.
`ifndef ADDRESS_RESOLUTION_TABLE_MACROS_SVH
`define ADDRESS_RESOLUTION_TABLE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ART_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define ART_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/art_pkg.sv
// Shared constants, codes and types of the address resolution table.
`default_nettype none

package art_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HW_W = 16;
    localparam int IP_W = 32;
    localparam int MAC_W = 48;
    localparam int COUNT_W = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (TABLE_ENTRIES > 31) ? COUNT_MAX : COUNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [HW_W-1:0]  hw;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef struct packed {
        logic load_key;
        logic scan;
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic cmp_last;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

### rtl/art_datapath.sv
// Datapath: key registers, entry memory, scan pipeline, valid bits and result register.
`default_nettype none

module art_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire art_pkg::cmd_t                 cmd,
    output art_pkg::sts_t                      sts,
    input  wire logic [1:0]                    operation,
    input  wire logic [art_pkg::HW_W-1:0]      hw_type,
    input  wire logic [art_pkg::IP_W-1:0]      ip_address,
    input  wire logic [art_pkg::MAC_W-1:0]     mac_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               status,
    output logic [art_pkg::MAC_W-1:0]          found_mac,
    output logic [art_pkg::COUNT_W-1:0]        entry_count
);

    art_pkg::entry_t mem [art_pkg::TABLE_ENTRIES];

    logic [1:0]                        op_reg;
    art_pkg::entry_t                   key_reg;
    logic [art_pkg::IDX_W-1:0]         addr_reg;
    logic                              issue_done_reg;
    logic                              pipe_v_reg;
    logic [art_pkg::IDX_W-1:0]         cmp_idx_reg;
    art_pkg::entry_t                   rd_data_reg;
    logic                              rd_vld_reg;
    logic                              hit_reg;
    logic [art_pkg::IDX_W-1:0]         hit_idx_reg;
    logic [art_pkg::MAC_W-1:0]         hit_mac_reg;
    logic [art_pkg::TABLE_ENTRIES-1:0] valid_reg;
    logic [art_pkg::COUNT_W-1:0]       count_reg;
    logic [art_pkg::COUNT_W-1:0]       count_next;
    logic                              out_valid_reg;
    logic                              status_reg;
    logic [art_pkg::MAC_W-1:0]         found_reg;
    logic [art_pkg::COUNT_W-1:0]       out_count_reg;

    logic match;
    logic issue;
    logic do_write;
    logic do_insert;

    always_comb
    begin
        match = 1'b0;
        case (op_reg)
            art_pkg::OP_INSERT: match = !rd_vld_reg;
            art_pkg::OP_UPDATE: match = rd_vld_reg && rd_data_reg.hw == key_reg.hw
                                        && rd_data_reg.ip == key_reg.ip;
            art_pkg::OP_LOOKUP: match = rd_vld_reg && rd_data_reg.ip == key_reg.ip;
            default:            match = 1'b0;
        endcase
    end

    assign issue      = cmd.scan && !issue_done_reg;
    assign do_insert  = hit_reg && op_reg == art_pkg::OP_INSERT;
    assign do_write   = do_insert || (hit_reg && op_reg == art_pkg::OP_UPDATE);
    assign count_next = (do_insert && count_reg != art_pkg::COUNT_MAX)
                        ? count_reg + 1'b1 : count_reg;

    assign sts.hit      = pipe_v_reg && match;
    assign sts.cmp_last = pipe_v_reg && cmp_idx_reg == art_pkg::LAST_IDX;
    assign sts.out_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            pipe_v_reg     <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_key)
            begin
                addr_reg       <= '0;
                issue_done_reg <= 1'b0;
                pipe_v_reg     <= 1'b0;
            end
            else if (issue)
            begin
                pipe_v_reg <= 1'b1;
                addr_reg   <= addr_reg + 1'b1;
                if (addr_reg == art_pkg::LAST_IDX)
                begin
                    issue_done_reg <= 1'b1;
                end
            end
            else
            begin
                pipe_v_reg <= 1'b0;
            end

            if (cmd.commit)
            begin
                if (do_insert)
                begin
                    valid_reg[hit_idx_reg] <= 1'b1;
                end
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_write)
        begin
            mem[hit_idx_reg] <= key_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            op_reg      <= operation;
            key_reg.hw  <= hw_type;
            key_reg.ip  <= ip_address;
            key_reg.mac <= mac_address;
        end
        if (issue)
        begin
            rd_vld_reg  <= valid_reg[addr_reg];
            cmp_idx_reg <= addr_reg;
        end
        if (cmd.capture)
        begin
            hit_reg     <= sts.hit;
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= rd_data_reg.mac;
        end
        if (cmd.commit)
        begin
            status_reg    <= hit_reg ? art_pkg::STATUS_OK : art_pkg::STATUS_FAIL;
            found_reg     <= (hit_reg && op_reg == art_pkg::OP_LOOKUP) ? hit_mac_reg : '0;
            out_count_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_mac   = found_reg;
    assign entry_count = out_count_reg;

endmodule

`default_nettype wire

### rtl/art_ctrl.sv
// Controller: state machine that sequences accept, scan and commit of one word.
`default_nettype none

module art_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire art_pkg::sts_t  sts,
    output art_pkg::cmd_t       cmd
);

    art_pkg::state_t state_reg;
    art_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= art_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            art_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = art_pkg::ST_SCAN;
                end
            end
            art_pkg::ST_SCAN:
            begin
                if (sts.hit || sts.cmp_last)
                begin
                    state_next = art_pkg::ST_FINISH;
                end
            end
            art_pkg::ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = art_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = art_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            art_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_key = in_valid;
            end
            art_pkg::ST_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.capture = sts.hit || sts.cmp_last;
            end
            art_pkg::ST_FINISH:
            begin
                cmd.commit = !sts.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/address_resolution_table.sv
// Path: a word that stops at entry i passes the key registers, the entry read register, the hit
// registers and the result register; a full scan reads all TABLE_ENTRIES entries.
// Throughput: one word per scan, set by the one-entry-per-cycle read of the entry memory, unless a
// stalled result register holds the commit; a new word is taken while the result register waits.
// Reset: rst_n clears all valid marks, the entry count and the controller at once.
`default_nettype none

module address_resolution_table
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    operation,
    input  wire logic [art_pkg::HW_W-1:0]      hw_type,
    input  wire logic [art_pkg::IP_W-1:0]      ip_address,
    input  wire logic [art_pkg::MAC_W-1:0]     mac_address,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               status,
    output logic [art_pkg::MAC_W-1:0]          found_mac,
    output logic [art_pkg::COUNT_W-1:0]        entry_count
);

    art_pkg::cmd_t cmd;
    art_pkg::sts_t sts;

    art_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    art_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (operation),
        .hw_type     (hw_type),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_mac   (found_mac),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

### rtl/art_checker.sv
// Port-level checker of the address resolution table and its bind.
`default_nettype none

`include "address_resolution_table_macros.svh"

module art_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          status,
    input wire logic [art_pkg::MAC_W-1:0]     found_mac,
    input wire logic [art_pkg::COUNT_W-1:0]   entry_count
);

    `ART_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(found_mac) && $stable(entry_count), "stalled result word changed")
    `ART_ASSERT_NOW(a_mac_zero_on_fail, out_valid && status == art_pkg::STATUS_FAIL, found_mac == '0, "failed word carries a MAC")
    `ART_ASSERT_NOW(a_count_cap, out_valid, entry_count <= art_pkg::COUNT_LIMIT, "entry count above table size")
    `ART_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again right after accept")

endmodule

bind address_resolution_table art_checker u_art_checker (.*);

`default_nettype wire

### tb/sv/address_resolution_table_checker.sv
// Checker for the address resolution table: predicts each reply and compares it with the block's.
`timescale 1ns / 100ps

module address_resolution_table_checker
    import art_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [HW_W-1:0]      hw_type,
    input  logic [IP_W-1:0]      ip_address,
    input  logic [MAC_W-1:0]     mac_address,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 status,
    input  logic [MAC_W-1:0]     found_mac,
    input  logic [COUNT_W-1:0]   entry_count,
    output logic [31:0]          fail_count,
    output logic [31:0]          words_pending
);

    typedef struct packed {
        logic               status;
        logic [MAC_W-1:0]   mac;
        logic [COUNT_W-1:0] count;
    } arp_reply_t;

    logic               tbl_valid [TABLE_ENTRIES];
    logic [HW_W-1:0]    tbl_hw    [TABLE_ENTRIES];
    logic [IP_W-1:0]    tbl_ip    [TABLE_ENTRIES];
    logic [MAC_W-1:0]   tbl_mac   [TABLE_ENTRIES];

    arp_reply_t         reply_queue [$];
    arp_reply_t         want;
    arp_reply_t         got;

    initial fail_count = 0;

    task automatic resolve_request(
        input  logic [1:0]       op,
        input  logic [HW_W-1:0]  hw,
        input  logic [IP_W-1:0]  ip,
        input  logic [MAC_W-1:0] mac,
        output arp_reply_t       reply
    );
        bit done;
        int filled;
        reply.status = STATUS_FAIL;
        reply.mac = '0;
        done = 0;
        filled = 0;
        case (op)
            OP_INSERT:
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!done && !tbl_valid[i])
                    begin
                        tbl_valid[i] = 1'b1;
                        tbl_hw[i] = hw;
                        tbl_ip[i] = ip;
                        tbl_mac[i] = mac;
                        reply.status = STATUS_OK;
                        done = 1;
                    end
            OP_UPDATE:
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!done && tbl_valid[i] && tbl_hw[i] == hw && tbl_ip[i] == ip)
                    begin
                        tbl_mac[i] = mac;
                        reply.status = STATUS_OK;
                        done = 1;
                    end
            OP_LOOKUP:
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!done && tbl_valid[i] && tbl_ip[i] == ip)
                    begin
                        reply.mac = tbl_mac[i];
                        reply.status = STATUS_OK;
                        done = 1;
                    end
            default:
                done = 0;
        endcase
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i])
                filled++;
        reply.count = (filled > COUNT_MAX) ? COUNT_MAX : COUNT_W'(filled);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tbl_valid[i] <= 1'b0;
            reply_queue.delete();
            words_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: reply with none outstanding: status %0d mac %h count %0d",
                                 $realtime, status, found_mac, entry_count);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (status !== want.status || found_mac !== want.mac ||
                        entry_count !== want.count)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: reply mismatch: expected status %0d mac %h ",
                                      "count %0d, got status %0d mac %h count %0d"},
                                     $realtime, want.status, want.mac, want.count,
                                     status, found_mac, entry_count);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                resolve_request(operation, hw_type, ip_address, mac_address, got);
                reply_queue.push_back(got);
            end
            words_pending <= reply_queue.size();
        end
    end

endmodule

### tb/sv/address_resolution_table_tb.sv
// Testbench top for the address resolution table: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module address_resolution_table_tb;
    import art_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1500;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           operation;
    logic [HW_W-1:0]      hw_type;
    logic [IP_W-1:0]      ip_address;
    logic [MAC_W-1:0]     mac_address;
    logic                 out_valid;
    logic                 out_stall;
    logic                 status;
    logic [MAC_W-1:0]     found_mac;
    logic [COUNT_W-1:0]   entry_count;
    logic [31:0]          fail_count;
    logic [31:0]          words_pending;

    logic [HW_W-1:0]      hw_pool [4];
    logic [IP_W-1:0]      ip_pool [8];
    int                   cycle_no;
    bit                   sender_quiet;

    address_resolution_table dut (.*);

    address_resolution_table_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("address_resolution_table_tb: FAIL");
        $finish;
    end

    initial
    begin
        out_stall <= 1'b0;
        cycle_no = 0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no >= 12000 && cycle_no < 20000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 8);
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_word(
        input logic [1:0]       op,
        input logic [HW_W-1:0]  hw,
        input logic [IP_W-1:0]  ip,
        input logic [MAC_W-1:0] mac
    );
        while (!sender_quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        hw_type <= hw;
        ip_address <= ip;
        mac_address <= mac;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random_request();
        int pick;
        logic [1:0]      op;
        logic [HW_W-1:0] hw;
        logic [IP_W-1:0] ip;
        pick = $urandom_range(99);
        if (pick < 10)
            op = OP_INSERT;
        else if (pick < 45)
            op = OP_UPDATE;
        else if (pick < 93)
            op = OP_LOOKUP;
        else
            op = OP_UNUSED;
        hw = ($urandom_range(99) < 85) ? hw_pool[$urandom_range(3)] : 16'($urandom);
        ip = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(7)] : 32'($urandom);
        send_word(op, hw, ip, random_mac());
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        operation <= OP_INSERT;
        hw_type <= '0;
        ip_address <= '0;
        mac_address <= '0;
        sender_quiet = 0;
        foreach (hw_pool[i])
            hw_pool[i] = 16'($urandom);
        foreach (ip_pool[i])
            ip_pool[i] = 32'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_LOOKUP, '0, '0, '0);
        send_word(OP_UPDATE, '1, '1, '1);
        send_word(OP_UNUSED, '1, '1, '1);
        send_word(OP_INSERT, '0, '0, '0);
        send_word(OP_INSERT, '1, '1, '1);
        send_word(OP_LOOKUP, '0, '0, '1);
        send_word(OP_LOOKUP, '1, '1, '0);
        send_word(OP_UPDATE, '1, '1, 48'h1234_5678_9abc);
        send_word(OP_LOOKUP, '0, '1, '0);
        send_word(OP_UPDATE, '0, '1, 48'h5555_5555_5555);
        send_word(OP_INSERT, 16'h0001, '0, 48'ha5a5_a5a5_a5a5);
        send_word(OP_LOOKUP, '0, '0, '0);
        send_word(OP_UPDATE, 16'h0001, '0, 48'h0f0f_0f0f_0f0f);
        send_word(OP_LOOKUP, '1, '0, '0);
        send_word(OP_UPDATE, '0, '0, 48'h8000_0000_0001);
        send_word(OP_LOOKUP, '0, '0, '0);
        send_word(OP_UNUSED, 16'h0001, '0, random_mac());
        send_word(OP_LOOKUP, '0, 32'h0000_0001, '0);
        send_word(OP_INSERT, hw_pool[0], ip_pool[0], random_mac());
        send_word(OP_LOOKUP, '0, ip_pool[0], '0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            sender_quiet = (n >= 400 && n < 700);
            if (n == 1000)
                drain_replies();
            send_random_request();
        end

        drain_replies();
        repeat (TABLE_ENTRIES + 3) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("address_resolution_table_tb: PASS");
        else
            $display("address_resolution_table_tb: FAIL");
        $finish;
    end

endmodule
